### rtl/core/bed_pkg.sv
package bed_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TEXT = 2'd0,
    CMD_SEP  = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_ESC_EN = 1'b0;
  localparam logic CFG_NL_EN  = 1'b1;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // One input's worth of result bytes, in emission order from index 0
  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
  } grp_t;

  // Decoder status seen by the top level
  typedef struct packed {
    logic stopped;
    logic pending;
  } dec_stat_t;

endpackage

### rtl/core/bed_decode.sv
module bed_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  bed_pkg::in_item_t item,
  input  logic              commit,
  input  logic              esc_en,
  input  logic              nl_en,
  output bed_pkg::grp_t     grp,
  output bed_pkg::dec_stat_t stat
);

  typedef enum logic [4:0] {
    PM_NORMAL = 5'b00001,
    PM_BSLASH = 5'b00010,
    PM_HEX0   = 5'b00100,
    PM_HEX1   = 5'b01000,
    PM_OCT    = 5'b10000
  } pmode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] BY_BEL    = 8'h07;
  localparam logic [7:0] BY_BS     = 8'h08;
  localparam logic [7:0] BY_ESC    = 8'h1B;
  localparam logic [7:0] BY_FF     = 8'h0C;
  localparam logic [7:0] BY_CR     = 8'h0D;
  localparam logic [7:0] BY_TAB    = 8'h09;
  localparam logic [7:0] BY_VT     = 8'h0B;

  localparam int unsigned CW = bed_pkg::CNT_W;

  pmode_t     mode_r, mode_nxt;
  logic [8:0] dv_r, dv_nxt;
  logic [1:0] dc_r, dc_nxt;
  logic       stop_r, stop_nxt;

  logic [7:0] b;
  logic       is_oct, is_hex;
  logic [3:0] hv;
  logic [8:0] dv_oct;
  logic [1:0] dc_inc;
  logic [7:0] clamp_dv, clamp_oct;
  logic [1:0] fl_cnt;
  logic [7:0] fl_b0, fl_b1;

  assign b      = item.data_byte;
  assign is_oct = (b[7:3] == 5'b00110);
  assign dv_oct = {dv_r[5:0], b[2:0]};
  assign dc_inc = dc_r + 2'd1;
  assign clamp_dv  = dv_r[8]   ? 8'hFF : dv_r[7:0];
  assign clamp_oct = dv_oct[8] ? 8'hFF : dv_oct[7:0];

  always_comb begin
    is_hex = 1'b1;
    hv     = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hv = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      hv = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // What ending the pending escape would emit
  always_comb begin
    fl_cnt = 2'd0;
    fl_b0  = CH_BSLASH;
    fl_b1  = CH_X;
    unique case (mode_r) inside
      PM_BSLASH: fl_cnt = 2'd1;
      PM_HEX0:   fl_cnt = 2'd2;
      PM_HEX1, PM_OCT: begin
        fl_cnt = 2'd1;
        fl_b0  = clamp_dv;
      end
      default:   fl_cnt = 2'd0;
    endcase
  end

  always_comb begin
    logic             do_flush;
    logic             do_plain;
    logic [1:0]       tail_n;
    logic [7:0]       tail0, tail1;
    logic [CW-1:0]    k;
    mode_nxt = mode_r;
    dv_nxt   = dv_r;
    dc_nxt   = dc_r;
    stop_nxt = stop_r;
    do_flush = 1'b0;
    do_plain = 1'b0;
    tail_n   = 2'd0;
    tail0    = b;
    tail1    = b;
    grp      = '0;
    k        = '0;

    if (item.cmd == bed_pkg::CMD_NONE) begin
      // ignored
    end else if (stop_r) begin
      if (item.cmd == bed_pkg::CMD_END) begin
        stop_nxt = 1'b0;
        mode_nxt = PM_NORMAL;
        dv_nxt   = '0;
        dc_nxt   = '0;
      end
    end else begin
      unique case (item.cmd)
        bed_pkg::CMD_SEP: begin
          do_flush = 1'b1;
          tail_n   = 2'd1;
          tail0    = CH_SPACE;
        end
        bed_pkg::CMD_END: begin
          do_flush = 1'b1;
          tail_n   = nl_en ? 2'd1 : 2'd0;
          tail0    = CH_NL;
        end
        default: begin
          if (!esc_en) begin
            do_flush = 1'b1;
            tail_n   = 2'd1;
          end else begin
            unique case (mode_r)
              PM_BSLASH: begin
                mode_nxt = PM_NORMAL;
                tail_n   = 2'd1;
                case (b)
                  CH_A:      tail0 = BY_BEL;
                  CH_B:      tail0 = BY_BS;
                  CH_E:      tail0 = BY_ESC;
                  CH_F:      tail0 = BY_FF;
                  CH_N:      tail0 = CH_NL;
                  CH_R:      tail0 = BY_CR;
                  CH_T:      tail0 = BY_TAB;
                  CH_V:      tail0 = BY_VT;
                  CH_BSLASH: tail0 = CH_BSLASH;
                  CH_C: begin
                    tail_n   = 2'd0;
                    stop_nxt = 1'b1;
                  end
                  CH_X: begin
                    tail_n   = 2'd0;
                    mode_nxt = PM_HEX0;
                  end
                  default: begin
                    if (is_oct) begin
                      tail_n   = 2'd0;
                      mode_nxt = PM_OCT;
                      dv_nxt   = {6'd0, b[2:0]};
                      dc_nxt   = 2'd1;
                    end else begin
                      // unknown escape: backslash then the byte
                      tail_n = 2'd2;
                      tail0  = CH_BSLASH;
                      tail1  = b;
                    end
                  end
                endcase
              end
              PM_HEX0: begin
                if (is_hex) begin
                  dv_nxt   = {5'd0, hv};
                  mode_nxt = PM_HEX1;
                end else begin
                  do_flush = 1'b1;
                  do_plain = 1'b1;
                end
              end
              PM_HEX1: begin
                if (is_hex) begin
                  tail_n   = 2'd1;
                  tail0    = {dv_r[3:0], hv};
                  mode_nxt = PM_NORMAL;
                  dv_nxt   = '0;
                end else begin
                  do_flush = 1'b1;
                  do_plain = 1'b1;
                end
              end
              PM_OCT: begin
                if (is_oct) begin
                  if (dc_inc == 2'd3) begin
                    tail_n   = 2'd1;
                    tail0    = clamp_oct;
                    mode_nxt = PM_NORMAL;
                    dv_nxt   = '0;
                    dc_nxt   = '0;
                  end else begin
                    dv_nxt = dv_oct;
                    dc_nxt = dc_inc;
                  end
                end else begin
                  do_flush = 1'b1;
                  do_plain = 1'b1;
                end
              end
              default: begin
                mode_nxt = PM_NORMAL;
                do_plain = 1'b1;
              end
            endcase
          end
        end
      endcase

      if (do_flush) begin
        mode_nxt = PM_NORMAL;
        dv_nxt   = '0;
        dc_nxt   = '0;
      end
      if (do_plain) begin
        if (b == CH_BSLASH) begin
          mode_nxt = PM_BSLASH;
        end else begin
          tail_n = 2'd1;
          tail0  = b;
        end
      end
      if (stop_nxt) begin
        mode_nxt = PM_NORMAL;
        dv_nxt   = '0;
        dc_nxt   = '0;
      end

      // Pack flush bytes then tail bytes, at most three in all
      if (do_flush && fl_cnt != 2'd0) begin
        grp.bytes[k[1:0]] = fl_b0;
        k = k + CW'(1);
      end
      if (do_flush && fl_cnt == 2'd2) begin
        grp.bytes[k[1:0]] = fl_b1;
        k = k + CW'(1);
      end
      if (tail_n != 2'd0 && k != CW'(bed_pkg::MAX_RESULTS)) begin
        grp.bytes[k[1:0]] = tail0;
        k = k + CW'(1);
      end
      if (tail_n == 2'd2 && k != CW'(bed_pkg::MAX_RESULTS)) begin
        grp.bytes[k[1:0]] = tail1;
        k = k + CW'(1);
      end
      grp.cnt = k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PM_NORMAL;
      dv_r   <= '0;
      dc_r   <= '0;
      stop_r <= 1'b0;
    end else if (commit) begin
      mode_r <= mode_nxt;
      dv_r   <= dv_nxt;
      dc_r   <= dc_nxt;
      stop_r <= stop_nxt;
    end
  end

  assign stat.stopped = stop_r;
  assign stat.pending = (mode_r != PM_NORMAL);

endmodule

### rtl/core/bed_outq.sv
module bed_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bed_pkg::grp_t      grp,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output bed_pkg::out_item_t out_item
);

  localparam int unsigned CW = bed_pkg::CNT_W;

  logic [bed_pkg::MAX_RESULTS-1:0][7:0] bytes_r;
  logic [CW-1:0]                        rem_r, rem_nxt;
  logic [1:0]                           idx_r, idx_nxt;
  logic                                 take;

  assign out_valid            = (rem_r != '0);
  assign take                 = out_valid && out_ready;
  assign can_load             = (rem_r == '0) || (rem_r == CW'(1) && out_ready);
  assign out_item.out_byte    = bytes_r[idx_r];
  assign out_item.last_of_run = (rem_r == CW'(1));

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (take) begin
      rem_nxt = rem_r - CW'(1);
      idx_nxt = idx_r + 2'd1;
    end
    if (load) begin
      rem_nxt = grp.cnt;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= grp.bytes;
    end
  end

endmodule

### rtl/core/backslash_escape_decoder.sv
// Path: an accepted beat waits in the input register until the decoder commits;
//   its results then go to the result register and are presented on out_*.
// Throughput: one input beat per cycle while out_ready holds high and each input
//   gives at most one result; more results (up to 3) hold the decoder until taken.
// Reset: synchronous, active low; clears the parser, the result register and sets
//   escape_enable to 0 and newline_enable to 1.
module backslash_escape_decoder (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  bed_pkg::in_item_t  in_item,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output bed_pkg::out_item_t out_item,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_wdata
);

  // Configuration registers
  logic esc_en_r;
  logic nl_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b0;
      nl_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bed_pkg::CFG_ESC_EN: esc_en_r <= cfg_wdata;
        bed_pkg::CFG_NL_EN:  nl_en_r  <= cfg_wdata;
        default:             esc_en_r <= esc_en_r;
      endcase
    end
  end

  // Input register: holds one beat until the decoder commits it
  logic              in_v_r;
  bed_pkg::in_item_t in_item_r;
  logic              commit;
  logic              in_take;

  bed_pkg::grp_t     grp;
  bed_pkg::dec_stat_t dec_stat;
  logic              can_load;
  logic              load;

  assign in_take  = in_valid && in_ready;
  assign in_ready = !in_v_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  // A beat with no results commits at once; one with results needs the
  // result register free (or freeing this cycle).
  assign commit = in_v_r && ((grp.cnt == '0) || can_load);
  assign load   = commit && (grp.cnt != '0);

  bed_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_item_r),
    .commit (commit),
    .esc_en (esc_en_r),
    .nl_en  (nl_en_r),
    .grp    (grp),
    .stat   (dec_stat)
  );

  bed_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // A loaded group must show up on the result port next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded result group not presented");

  // After a stop escape, nothing is emitted until end of message
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    dec_stat.stopped |-> (grp.cnt == '0))
    else $error("result produced while output stopped");

  // A held input beat keeps its payload until the decoder commits it
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !commit) |=> (in_v_r && $stable(in_item_r)))
    else $error("input register lost an uncommitted beat");

  // While stopped no escape is left pending
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    dec_stat.stopped |-> !dec_stat.pending)
    else $error("escape pending while output stopped");

endmodule

### tb/sv/backslash_escape_decoder_tb.sv
`timescale 1ns / 100ps

module backslash_escape_decoder_tb;

  localparam int SETTLE_CYCLES  = 8;     // covers the input and result registers plus slack
  localparam int HOLD_CYCLES    = 150;   // long sink stall, fills the block
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any beat while busy
  localparam int NUM_PHASES     = 5;

  localparam logic [7:0] BSLASH    = 8'h5C;
  localparam logic [7:0] ASCII_ESC = 8'h1B;
  localparam logic [7:0] ASCII_SP  = 8'h20;
  localparam logic [7:0] ASCII_LF  = 8'h0A;

  // Decoder parse states
  typedef enum logic [2:0] {
    PM_NORMAL = 3'd0,
    PM_BSLASH = 3'd1,
    PM_HEX0   = 3'd2,
    PM_HEX1   = 3'd3,
    PM_OCT    = 3'd4
  } parse_mode_t;

  // Random phases: register settings, idle odds (percent) and item counts
  int ph_esc   [NUM_PHASES] = '{1, 1, 0, 1, 0};
  int ph_nl    [NUM_PHASES] = '{1, 0, 0, 1, 1};
  int ph_src   [NUM_PHASES] = '{20, 0, 60, 40, 0};
  int ph_snk   [NUM_PHASES] = '{20, 0, 60, 0, 50};
  int ph_items [NUM_PHASES] = '{80, 60, 35, 50, 35};

  // Escape letters with a fixed meaning; \c is drawn separately, less often
  string named_esc = "abefnrtv\\";
  string hex_chars = "0123456789abcdefABCDEF";

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  bed_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bed_pkg::out_item_t out_item;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = 1'b0;
  logic               cfg_wdata = 1'b0;

  // Stimulus and scoreboard storage
  bed_pkg::in_item_t  arg_stream_q[$];   // beats waiting to be driven
  bed_pkg::out_item_t decoded_q[$];      // predicted output beats, oldest first
  logic [7:0]         run_bytes[$];      // bytes produced by the beat being decoded

  int queued_items = 0;         // beats that matter (cmd 3 excluded)
  int src_pct      = 0;
  int snk_pct      = 0;
  int src_wait     = 0;
  int snk_wait     = 0;
  int hold_left    = 0;
  int holds_wanted = 0;
  int holds_done   = 0;
  int stall_cycles = 0;
  int mismatches   = 0;

  // Shadow of the decoder state and registers
  logic        esc_en;
  logic        nl_en;
  parse_mode_t pmode;
  logic [8:0]  dval;
  logic [1:0]  dcnt;
  logic        stopped;

  function automatic bit is_oct(input logic [7:0] b);
    return b >= "0" && b <= "7";
  endfunction

  function automatic bit is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // Only called on hex digits: letters land on low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (b <= "9") return b[3:0];
    return b[3:0] + 4'd9;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (run_bytes.size() < bed_pkg::MAX_RESULTS) run_bytes.push_back(b);
  endfunction

  // Close whatever escape is open, as at an argument boundary
  function automatic void end_escape();
    case (pmode) inside
      PM_BSLASH: emit(BSLASH);
      PM_HEX0: begin
        emit(BSLASH);
        emit("x");
      end
      PM_HEX1, PM_OCT: emit((dval > 9'd255) ? 8'hFF : dval[7:0]);
      default: ;
    endcase
    pmode = PM_NORMAL;
    dval  = '0;
    dcnt  = '0;
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == BSLASH) pmode = PM_BSLASH;
    else emit(b);
  endfunction

  function automatic void escaped_byte(input logic [7:0] b);
    case (pmode)
      PM_BSLASH: begin
        pmode = PM_NORMAL;
        case (b)
          "a":    emit(8'h07);
          "b":    emit(8'h08);
          "e":    emit(ASCII_ESC);
          "f":    emit(8'h0C);
          "n":    emit(ASCII_LF);
          "r":    emit(8'h0D);
          "t":    emit(8'h09);
          "v":    emit(8'h0B);
          BSLASH: emit(BSLASH);
          "c":    stopped = 1'b1;
          "x":    pmode = PM_HEX0;
          default: begin
            if (is_oct(b)) begin
              pmode = PM_OCT;
              dval  = {6'd0, b[2:0]};
              dcnt  = 2'd1;
            end else begin
              // unknown escape goes out literally
              emit(BSLASH);
              emit(b);
            end
          end
        endcase
      end
      PM_HEX0: begin
        if (is_hex(b)) begin
          dval  = {5'd0, hex_val(b)};
          pmode = PM_HEX1;
        end else begin
          end_escape();
          plain_byte(b);
        end
      end
      PM_HEX1: begin
        if (is_hex(b)) begin
          emit({dval[3:0], hex_val(b)});
          pmode = PM_NORMAL;
          dval  = '0;
        end else begin
          end_escape();
          plain_byte(b);
        end
      end
      PM_OCT: begin
        if (is_oct(b)) begin
          dval = {dval[5:0], b[2:0]};
          dcnt = dcnt + 2'd1;
          if (dcnt == 2'd3) end_escape();
        end else begin
          end_escape();
          plain_byte(b);
        end
      end
      default: begin
        pmode = PM_NORMAL;
        plain_byte(b);
      end
    endcase
  endfunction

  // Advance the shadow decoder by one accepted beat and queue its output bytes
  function automatic void decode_beat(input bed_pkg::in_item_t it);
    run_bytes.delete();
    if (it.cmd == bed_pkg::CMD_NONE) return;
    if (stopped) begin
      if (it.cmd == bed_pkg::CMD_END) begin
        stopped = 1'b0;
        pmode   = PM_NORMAL;
        dval    = '0;
        dcnt    = '0;
      end
      return;
    end
    case (it.cmd)
      bed_pkg::CMD_TEXT: begin
        if (esc_en) begin
          escaped_byte(it.data_byte);
        end else begin
          end_escape();
          emit(it.data_byte);
        end
      end
      bed_pkg::CMD_SEP: begin
        end_escape();
        emit(ASCII_SP);
      end
      default: begin
        end_escape();
        if (nl_en) emit(ASCII_LF);
      end
    endcase
    if (stopped) begin
      pmode = PM_NORMAL;
      dval  = '0;
      dcnt  = '0;
    end
    foreach (run_bytes[i])
      decoded_q.push_back('{out_byte: run_bytes[i],
                            last_of_run: (i == run_bytes.size() - 1)});
  endfunction

  function automatic int draw_wait(input int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 19)) : 0;
  endfunction

  backslash_escape_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Input driver: the beat in flight is predicted the edge it is taken, then
  // the next one is offered after its drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (in_valid && in_ready) decode_beat(in_item);
      if (!in_valid || in_ready) begin
        if (src_wait != 0) begin
          in_valid <= 1'b0;
          src_wait <= src_wait - 1;
        end else if (arg_stream_q.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= arg_stream_q.pop_front();
          src_wait <= draw_wait(src_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and sink: compares each beat with the oldest prediction,
  // then picks the ready pattern (long hold, drawn gap or always ready).
  always @(posedge clk) begin : result_sink
    bed_pkg::out_item_t want;
    int                 w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, got byte %h last %b",
                   $time, out_item.out_byte, out_item.last_of_run);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, got %h",
                     $time, want.out_byte, out_item.out_byte);
            mismatches++;
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch: expected %b, got %b",
                     $time, want.last_of_run, out_item.last_of_run);
            mismatches++;
          end
        end
      end
      if (holds_done != holds_wanted) begin
        holds_done <= holds_done + 1;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_valid && out_ready) begin
        w = draw_wait(snk_pct);
        snk_wait  <= w;
        out_ready <= (w == 0);
      end else if (snk_wait != 0) begin
        snk_wait  <= snk_wait - 1;
        out_ready <= (snk_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (arg_stream_q.size() == 0 && !in_valid && decoded_q.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic void push_item(input bed_pkg::cmd_t c, input logic [7:0] b);
    arg_stream_q.push_back('{cmd: c, data_byte: b});
    if (c != bed_pkg::CMD_NONE) queued_items++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(bed_pkg::CMD_TEXT, s[i]);
  endfunction

  // One token of argument text: mostly plain bytes and well-formed escapes,
  // with some raw noise and ignored beats mixed in.
  function automatic void queue_token();
    int n;
    case ($urandom_range(0, 9)) inside
      0, 1, 2: push_item(bed_pkg::CMD_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
      3:       push_item(bed_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
      4:       push_item(bed_pkg::CMD_NONE, 8'($urandom_range(0, 255)));
      5, 6: begin
        push_item(bed_pkg::CMD_TEXT, BSLASH);
        if ($urandom_range(0, 15) == 0) push_item(bed_pkg::CMD_TEXT, "c");
        else push_item(bed_pkg::CMD_TEXT,
                       named_esc[$urandom_range(0, named_esc.len() - 1)]);
      end
      7: begin
        // \x with 0..3 digits; a third digit falls back to plain text
        push_item(bed_pkg::CMD_TEXT, BSLASH);
        push_item(bed_pkg::CMD_TEXT, "x");
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
          push_item(bed_pkg::CMD_TEXT,
                    hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      end
      8: begin
        // octal run, sometimes longer than three digits
        push_item(bed_pkg::CMD_TEXT, BSLASH);
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
          push_item(bed_pkg::CMD_TEXT, 8'($urandom_range(8'h30, 8'h37)));
      end
      default: begin
        push_item(bed_pkg::CMD_TEXT, BSLASH);
        push_item(bed_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // A message of 1..3 arguments; now and then the end mark is left off
  function automatic void queue_message();
    int nargs;
    int ntok;
    nargs = $urandom_range(1, 3);
    for (int a = 0; a < nargs; a++) begin
      ntok = $urandom_range(0, 5);
      for (int t = 0; t < ntok; t++) queue_token();
      if (a != nargs - 1) push_item(bed_pkg::CMD_SEP, 8'($urandom));
    end
    if ($urandom_range(0, 7) != 0) push_item(bed_pkg::CMD_END, 8'($urandom));
  endfunction

  // Block is drained: nothing to drive, nothing predicted, pipe given time
  task automatic wait_idle();
    do @(posedge clk);
    while (arg_stream_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bed_pkg::CFG_ESC_EN) esc_en = val;
    else nl_en = val;
  endtask

  initial begin : stimulus
    int target;
    esc_en  = 1'b0;
    nl_en   = 1'b1;
    pmode   = PM_NORMAL;
    dval    = '0;
    dcnt    = '0;
    stopped = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Escapes off (reset value): extremes of the byte, backslash passes as-is,
    // ignored command, separator and end with newline
    push_item(bed_pkg::CMD_TEXT, 8'h00);
    push_item(bed_pkg::CMD_TEXT, 8'hFF);
    push_item(bed_pkg::CMD_TEXT, BSLASH);
    push_item(bed_pkg::CMD_NONE, 8'hA5);
    push_item(bed_pkg::CMD_SEP, 8'h5A);
    push_item(bed_pkg::CMD_END, 8'hFF);
    wait_idle();

    // Escapes on: unknown escape, \x without digit, hex cut by separator,
    // octal clamp, octal cut short, trailing backslash, \c stop
    write_reg(bed_pkg::CFG_ESC_EN, 1'b1);
    push_text("\\q\\xg\\x7");
    push_item(bed_pkg::CMD_SEP, 8'h00);
    push_text("\\777\\1z\\");
    push_item(bed_pkg::CMD_END, 8'h00);
    push_text("\\ca");
    push_item(bed_pkg::CMD_END, 8'h00);
    push_text("\\x");   // left open across the register write below
    wait_idle();

    // Escapes turned off with \x pending: next byte closes it first
    write_reg(bed_pkg::CFG_ESC_EN, 1'b0);
    push_text("k");
    push_item(bed_pkg::CMD_END, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(bed_pkg::CFG_ESC_EN, ph_esc[p][0]);
      write_reg(bed_pkg::CFG_NL_EN, ph_nl[p][0]);
      src_pct = ph_src[p];
      snk_pct = ph_snk[p];
      target  = queued_items + ph_items[p];
      while (queued_items < target) queue_message();
      // back-pressure: sink stalls while the source keeps offering
      if (p == 0) holds_wanted++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bed_pkg.sv
rtl/core/bed_decode.sv
rtl/core/bed_outq.sv
rtl/core/backslash_escape_decoder.sv
tb/sv/backslash_escape_decoder_tb.sv
